[rtl/twrt_pkg.sv]
package twrt_pkg;

  // Field widths fixed by the item format.
  localparam int unsigned TIME_W  = 19;
  localparam int unsigned LEVEL_W = 10;
  localparam int unsigned MS_W    = 32;
  localparam int unsigned SEC_W   = 17;

  // Milliseconds to seconds: floor(ms / 1000) = floor((ms >> 3) * MS_RECIP >> MS_SHIFT).
  localparam int unsigned MS_PRE_SHIFT = 3;
  localparam int unsigned MS_X_W       = MS_W - MS_PRE_SHIFT;
  localparam int unsigned MS_RECIP_W   = 30;
  localparam logic [MS_RECIP_W-1:0] MS_RECIP = 30'd549755814;
  localparam int unsigned MS_SHIFT     = 36;
  localparam int unsigned SECS_W       = 23;

  // Days: floor(s / 86400) = floor((s >> 7) * DAY_RECIP >> DAY_SHIFT).
  localparam int unsigned DAY_PRE_SHIFT = 7;
  localparam int unsigned DAY_X_W       = SECS_W - DAY_PRE_SHIFT;
  localparam int unsigned DAY_RECIP_W   = 17;
  localparam logic [DAY_RECIP_W-1:0] DAY_RECIP = 17'd99421;
  localparam int unsigned DAY_SHIFT     = 26;
  localparam int unsigned DAYS_W        = 6;
  localparam logic [SEC_W-1:0] DAY_SECONDS = 17'd86400;

  typedef enum logic {
    CMD_ADD   = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    STATUS_ADDED   = 2'd0,
    STATUS_FULL    = 2'd1,
    STATUS_ANSWER  = 2'd2,
    STATUS_UNUSED  = 2'd3
  } status_e;

  // One stored rule.
  typedef struct packed {
    logic [TIME_W-1:0]  start_sec;
    logic [TIME_W-1:0]  end_sec;
    logic [LEVEL_W-1:0] level;
  } rule_t;

  // Result of the seconds-of-day unit.
  typedef struct packed {
    logic             done;
    logic [SEC_W-1:0] sec;
  } sod_res_t;

endpackage

[rtl/twrt_sec_of_day.sv]
module twrt_sec_of_day (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [twrt_pkg::MS_W-1:0]     time_ms_i,
  output twrt_pkg::sod_res_t            res_o
);

  localparam int unsigned P1_W = twrt_pkg::MS_X_W + twrt_pkg::MS_RECIP_W;
  localparam int unsigned P2_W = twrt_pkg::DAY_X_W + twrt_pkg::DAY_RECIP_W;
  localparam int unsigned P3_W = twrt_pkg::DAYS_W + twrt_pkg::SEC_W;

  logic [4:0]                     stage_q;
  logic [P1_W-1:0]                p1_q;
  logic [twrt_pkg::SECS_W-1:0]    secs_q;
  logic [P2_W-1:0]                p2_q;
  logic [P3_W-1:0]                p3_q;
  logic [twrt_pkg::SEC_W-1:0]     sec_q;
  logic [twrt_pkg::DAYS_W-1:0]    days;
  logic [twrt_pkg::SECS_W-1:0]    day_base;

  // Stage tracker: one bit per pipeline step.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= '0;
    end else begin
      stage_q <= {stage_q[3:0], start_i};
    end
  end

  assign days     = p2_q[twrt_pkg::DAY_SHIFT +: twrt_pkg::DAYS_W];
  assign day_base = p3_q[twrt_pkg::SECS_W-1:0];

  // Reciprocal multiplications, the days-to-seconds product and the subtraction, each followed by a register.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      p1_q <= P1_W'(time_ms_i[twrt_pkg::MS_W-1:twrt_pkg::MS_PRE_SHIFT]) *
              P1_W'(twrt_pkg::MS_RECIP);
    end
    if (stage_q[0]) begin
      secs_q <= p1_q[twrt_pkg::MS_SHIFT +: twrt_pkg::SECS_W];
    end
    if (stage_q[1]) begin
      p2_q <= P2_W'(secs_q[twrt_pkg::SECS_W-1:twrt_pkg::DAY_PRE_SHIFT]) *
              P2_W'(twrt_pkg::DAY_RECIP);
    end
    if (stage_q[2]) begin
      p3_q <= P3_W'(days) * P3_W'(twrt_pkg::DAY_SECONDS);
    end
    if (stage_q[3]) begin
      sec_q <= twrt_pkg::SEC_W'(secs_q - day_base);
    end
  end

  assign res_o.done = stage_q[4];
  assign res_o.sec  = sec_q;

endmodule

[rtl/time_window_rule_table_top.sv]
// Add request: the status is registered, then loaded into the output register when it is free.
// Query request: the seconds-of-day unit reduces the time, then the stored rules are read
// from the rule memory one per cycle (one read port, registered read) until one matches or the
// last has been tested; the result is then registered. One request is in work at a time.
// Reset clears the rule count and all control state; the rule memory is not cleared.
module time_window_rule_table_top #(
  parameter int unsigned MAX_RULES = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          cmd_i,
  input  logic [twrt_pkg::TIME_W-1:0]   start_seconds_i,
  input  logic [twrt_pkg::TIME_W-1:0]   end_seconds_i,
  input  logic [twrt_pkg::LEVEL_W-1:0]  level_i,
  input  logic [twrt_pkg::MS_W-1:0]     time_ms_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    status_o,
  output logic [twrt_pkg::LEVEL_W-1:0]  intensity_o,
  output logic                          matched_o
);

  localparam int unsigned ADDR_W = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_RULES + 1);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SOD  = 4'b0010,
    ST_SCAN = 4'b0100,
    ST_DONE = 4'b1000
  } state_e;

  state_e                          state_q, state_d;
  logic [CNT_W-1:0]                count_q, count_d;
  logic [CNT_W-1:0]                scan_idx_q, scan_idx_d;
  logic                            rd_vld_q, rd_last_q;
  logic                            rd_en;
  twrt_pkg::rule_t                 mem_q [MAX_RULES];
  twrt_pkg::rule_t                 rd_data_q;
  logic                            wr_en;
  logic [twrt_pkg::SEC_W-1:0]      sec_q, sec_d;
  twrt_pkg::status_e               res_status_q, res_status_d;
  logic [twrt_pkg::LEVEL_W-1:0]    res_level_q, res_level_d;
  logic                            res_hit_q, res_hit_d;
  logic                            out_valid_q, out_valid_d;
  logic [1:0]                      out_status_q;
  logic [twrt_pkg::LEVEL_W-1:0]    out_level_q;
  logic                            out_hit_q;
  logic                            in_acc, out_load, sod_start, hit;
  logic [twrt_pkg::TIME_W-1:0]     sec_ext;
  twrt_pkg::sod_res_t              sod_res;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign sod_start  = in_acc && (twrt_pkg::cmd_e'(cmd_i) == twrt_pkg::CMD_QUERY);
  assign wr_en      = in_acc && (twrt_pkg::cmd_e'(cmd_i) == twrt_pkg::CMD_ADD) &&
                      (count_q < CNT_W'(MAX_RULES));
  assign rd_en      = (state_q == ST_SCAN) && (scan_idx_q < count_q);
  assign out_load   = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  // Seconds of the day for a query.
  twrt_sec_of_day u_sod (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (sod_start),
    .time_ms_i (time_ms_i),
    .res_o     (sod_res)
  );

  // Window test on the rule just read; a window with equal ends never matches.
  assign sec_ext = twrt_pkg::TIME_W'(sec_q);
  always_comb begin
    if (rd_data_q.start_sec < rd_data_q.end_sec) begin
      hit = (sec_ext >= rd_data_q.start_sec) && (sec_ext < rd_data_q.end_sec);
    end else if (rd_data_q.start_sec > rd_data_q.end_sec) begin
      hit = (sec_ext >= rd_data_q.start_sec) || (sec_ext < rd_data_q.end_sec);
    end else begin
      hit = 1'b0;
    end
  end

  // Rule memory: written on add, read during the scan.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[count_q[ADDR_W-1:0]] <= '{start_sec: start_seconds_i,
                                      end_sec:   end_seconds_i,
                                      level:     level_i};
    end
    if (rd_en) begin
      rd_data_q <= mem_q[scan_idx_q[ADDR_W-1:0]];
    end
  end

  // Sequencer.
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    scan_idx_d   = scan_idx_q;
    sec_d        = sec_q;
    res_status_d = res_status_q;
    res_level_d  = res_level_q;
    res_hit_d    = res_hit_q;
    out_valid_d  = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          res_level_d = '0;
          res_hit_d   = 1'b0;
          if (twrt_pkg::cmd_e'(cmd_i) == twrt_pkg::CMD_QUERY) begin
            res_status_d = twrt_pkg::STATUS_ANSWER;
            state_d      = ST_SOD;
          end else begin
            if (wr_en) begin
              count_d      = count_q + 1'b1;
              res_status_d = twrt_pkg::STATUS_ADDED;
            end else begin
              res_status_d = twrt_pkg::STATUS_FULL;
            end
            state_d = ST_DONE;
          end
        end
      end
      ST_SOD: begin
        if (sod_res.done) begin
          sec_d      = sod_res.sec;
          scan_idx_d = '0;
          state_d    = (count_q == '0) ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (rd_en) begin
          scan_idx_d = scan_idx_q + 1'b1;
        end
        if (rd_vld_q) begin
          if (hit) begin
            res_level_d = rd_data_q.level;
            res_hit_d   = 1'b1;
            state_d     = ST_DONE;
          end else if (rd_last_q) begin
            state_d = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      scan_idx_q  <= '0;
      rd_vld_q    <= 1'b0;
      rd_last_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      scan_idx_q  <= scan_idx_d;
      rd_vld_q    <= rd_en;
      rd_last_q   <= (scan_idx_q == (count_q - 1'b1));
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    sec_q        <= sec_d;
    res_status_q <= res_status_d;
    res_level_q  <= res_level_d;
    res_hit_q    <= res_hit_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_level_q  <= res_level_q;
      out_hit_q    <= res_hit_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign intensity_o = out_level_q;
  assign matched_o   = out_hit_q;

endmodule

[tb/time_window_rule_table_top_test.sv]
module time_window_rule_table_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_RULES    = 32;
  localparam int unsigned MS_PER_SEC   = 1000;
  localparam int unsigned SEC_PER_DAY  = 86400;
  localparam int          PLAN_ROWS    = 18;
  localparam int          RANDOM_ITEMS = 1100;
  localparam int          HOLD_AT      = 300;
  localparam int          HOLD_CYCLES  = 400;
  localparam int          DRAIN_CYCLES = 2 * (MAX_RULES + 8);
  localparam int          STALL_LIMIT  = 3000;

  // One request as offered on the input side.
  typedef struct packed {
    twrt_pkg::cmd_e                cmd;
    logic [twrt_pkg::TIME_W-1:0]   start_s;
    logic [twrt_pkg::TIME_W-1:0]   end_s;
    logic [twrt_pkg::LEVEL_W-1:0]  lvl;
    logic [twrt_pkg::MS_W-1:0]     ms;
  } sched_req_t;

  // One answer as returned on the output side.
  typedef struct packed {
    twrt_pkg::status_e             st;
    logic [twrt_pkg::LEVEL_W-1:0]  inten;
    logic                          hit;
  } sched_ans_t;

  // Directed row: the answer is typed in only where typed is set.
  typedef struct packed {
    sched_req_t req;
    bit         typed;
    sched_ans_t ans;
  } plan_row_t;

  logic                          clk_i;
  logic                          rst_ni          = 1'b0;
  logic                          in_valid_i      = 1'b0;
  logic                          in_ready_o;
  logic                          cmd_i           = 1'b0;
  logic [twrt_pkg::TIME_W-1:0]   start_seconds_i = '0;
  logic [twrt_pkg::TIME_W-1:0]   end_seconds_i   = '0;
  logic [twrt_pkg::LEVEL_W-1:0]  level_i         = '0;
  logic [twrt_pkg::MS_W-1:0]     time_ms_i       = '0;
  logic                          out_valid_o;
  logic                          out_ready_i     = 1'b0;
  logic [1:0]                    status_o;
  logic [twrt_pkg::LEVEL_W-1:0]  intensity_o;
  logic                          matched_o;

  // Shadow copy of the rule table.
  logic [twrt_pkg::TIME_W-1:0]   rule_start [MAX_RULES];
  logic [twrt_pkg::TIME_W-1:0]   rule_end   [MAX_RULES];
  logic [twrt_pkg::LEVEL_W-1:0]  rule_level [MAX_RULES];
  int unsigned                   rule_total = 0;

  sched_ans_t owed_answers [$];
  bit         tx_calm       = 1'b0;
  int         mismatches    = 0;
  int         answers_taken = 0;
  int         quiet_cycles  = 0;
  int         n_stored      = 0;
  int         n_dropped     = 0;
  int         n_queries     = 0;
  int         n_hits        = 0;

  // Directed requests: empty table, extreme fields, wrapping, empty and out-of-range windows.
  plan_row_t plan [PLAN_ROWS] = '{
    '{'{twrt_pkg::CMD_QUERY, 19'd0, 19'd0, 10'd0, 32'd0}, 1'b1,
      '{twrt_pkg::STATUS_ANSWER, 10'd0, 1'b0}},
    '{'{twrt_pkg::CMD_QUERY, 19'h7FFFF, 19'h7FFFF, 10'h3FF, 32'hFFFFFFFF}, 1'b1,
      '{twrt_pkg::STATUS_ANSWER, 10'd0, 1'b0}},
    '{'{twrt_pkg::CMD_ADD, 19'd3600, 19'd7200, 10'd0, 32'd0}, 1'b1,
      '{twrt_pkg::STATUS_ADDED, 10'd0, 1'b0}},
    '{'{twrt_pkg::CMD_ADD, 19'd86000, 19'd30, 10'd1000, 32'hFFFFFFFF}, 1'b1,
      '{twrt_pkg::STATUS_ADDED, 10'd0, 1'b0}},
    '{'{twrt_pkg::CMD_ADD, 19'd10000, 19'd10000, 10'h3FF, 32'd0}, 1'b1,
      '{twrt_pkg::STATUS_ADDED, 10'd0, 1'b0}},
    '{'{twrt_pkg::CMD_ADD, 19'h7FFFF, 19'd60, 10'd5, 32'd0}, 1'b1,
      '{twrt_pkg::STATUS_ADDED, 10'd0, 1'b0}},
    '{'{twrt_pkg::CMD_ADD, 19'd86400, 19'h7FFFF, 10'd777, 32'd0}, 1'b1,
      '{twrt_pkg::STATUS_ADDED, 10'd0, 1'b0}},
    '{'{twrt_pkg::CMD_QUERY, 19'd0, 19'd0, 10'd0, 32'd3600000}, 1'b0,
      '{twrt_pkg::STATUS_ANSWER, 10'd0, 1'b0}},
    '{'{twrt_pkg::CMD_QUERY, 19'd0, 19'd0, 10'd0, 32'd7199999}, 1'b0,
      '{twrt_pkg::STATUS_ANSWER, 10'd0, 1'b0}},
    '{'{twrt_pkg::CMD_QUERY, 19'd0, 19'd0, 10'd0, 32'd7200000}, 1'b0,
      '{twrt_pkg::STATUS_ANSWER, 10'd0, 1'b0}},
    '{'{twrt_pkg::CMD_QUERY, 19'd0, 19'd0, 10'd0, 32'd0}, 1'b0,
      '{twrt_pkg::STATUS_ANSWER, 10'd0, 1'b0}},
    '{'{twrt_pkg::CMD_QUERY, 19'd0, 19'd0, 10'd0, 32'd86399999}, 1'b0,
      '{twrt_pkg::STATUS_ANSWER, 10'd0, 1'b0}},
    '{'{twrt_pkg::CMD_QUERY, 19'd0, 19'd0, 10'd0, 32'd45000}, 1'b0,
      '{twrt_pkg::STATUS_ANSWER, 10'd0, 1'b0}},
    '{'{twrt_pkg::CMD_QUERY, 19'd0, 19'd0, 10'd0, 32'd10000000}, 1'b0,
      '{twrt_pkg::STATUS_ANSWER, 10'd0, 1'b0}},
    '{'{twrt_pkg::CMD_QUERY, 19'd0, 19'd0, 10'd0, 32'd86400000}, 1'b0,
      '{twrt_pkg::STATUS_ANSWER, 10'd0, 1'b0}},
    '{'{twrt_pkg::CMD_QUERY, 19'd0, 19'd0, 10'd0, 32'hFFFFFFFF}, 1'b0,
      '{twrt_pkg::STATUS_ANSWER, 10'd0, 1'b0}},
    '{'{twrt_pkg::CMD_QUERY, 19'd0, 19'd0, 10'd0, 32'd30000}, 1'b0,
      '{twrt_pkg::STATUS_ANSWER, 10'd0, 1'b0}},
    '{'{twrt_pkg::CMD_QUERY, 19'd0, 19'd0, 10'd0, 32'd3599999}, 1'b0,
      '{twrt_pkg::STATUS_ANSWER, 10'd0, 1'b0}}
  };

  time_window_rule_table_top #(
    .MAX_RULES(MAX_RULES)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .cmd_i          (cmd_i),
    .start_seconds_i(start_seconds_i),
    .end_seconds_i  (end_seconds_i),
    .level_i        (level_i),
    .time_ms_i      (time_ms_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .intensity_o    (intensity_o),
    .matched_o      (matched_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Applies one request to the shadow table and returns the answer it must produce.
  function automatic sched_ans_t answer_request(sched_req_t r);
    sched_ans_t  a;
    int unsigned sec;
    int unsigned i;
    bit          in_win;
    a.st    = twrt_pkg::STATUS_ANSWER;
    a.inten = '0;
    a.hit   = 1'b0;
    if (r.cmd == twrt_pkg::CMD_ADD) begin
      if (rule_total < MAX_RULES) begin
        rule_start[rule_total] = r.start_s;
        rule_end[rule_total]   = r.end_s;
        rule_level[rule_total] = r.lvl;
        rule_total++;
        a.st = twrt_pkg::STATUS_ADDED;
      end else begin
        a.st = twrt_pkg::STATUS_FULL;
      end
    end else begin
      sec = (r.ms / MS_PER_SEC) % SEC_PER_DAY;
      // First rule in insertion order whose window holds the second wins.
      for (i = 0; i < rule_total; i++) begin
        if (rule_start[i] < rule_end[i]) begin
          in_win = sec >= rule_start[i] && sec < rule_end[i];
        end else begin
          in_win = rule_start[i] > rule_end[i] && (sec >= rule_start[i] || sec < rule_end[i]);
        end
        if (in_win && !a.hit) begin
          a.inten = rule_level[i];
          a.hit   = 1'b1;
        end
      end
    end
    return a;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  // Waits a drawn number of cycles, offers one request and records its answer when taken.
  task automatic offer_request(sched_req_t r, bit typed, sched_ans_t typed_ans);
    int unsigned gap;
    sched_ans_t  want;
    gap = tx_calm ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_i           <= r.cmd;
    start_seconds_i <= r.start_s;
    end_seconds_i   <= r.end_s;
    level_i         <= r.lvl;
    time_ms_i       <= r.ms;
    in_valid_i      <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    want = answer_request(r);
    case (want.st)
      twrt_pkg::STATUS_ADDED: n_stored++;
      twrt_pkg::STATUS_FULL:  n_dropped++;
      default: begin
        n_queries++;
        if (want.hit) n_hits++;
      end
    endcase
    if (typed) want = typed_ans;
    owed_answers.push_back(want);
  endtask

  // Stimulus: reset, the directed table, then random requests.
  initial begin : stimulus
    sched_req_t      r;
    sched_ans_t      no_ans;
    int              n;
    int unsigned     s;
    int unsigned     e;
    int unsigned     sec;
    int unsigned     k;
    bit              is_add;
    longint unsigned t;
    no_ans = '{twrt_pkg::STATUS_ANSWER, 10'd0, 1'b0};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (n = 0; n < PLAN_ROWS; n++) begin
      offer_request(plan[n].req, plan[n].typed, plan[n].ans);
    end

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if ($urandom_range(0, 49) == 0) tx_calm = !tx_calm;
      // Fill the table with queries mixed in, then mostly query with a few dropped adds.
      if (rule_total < MAX_RULES) is_add = $urandom_range(0, 9) < 6;
      else is_add = $urandom_range(0, 19) == 0;
      if (is_add) begin
        r.cmd = twrt_pkg::CMD_ADD;
        r.ms  = $urandom();
        r.lvl = ($urandom_range(0, 7) == 0) ? 10'($urandom()) : 10'($urandom_range(0, 1000));
        case ($urandom_range(0, 15))
          0, 1, 2, 3, 4, 5, 6, 7, 8: begin
            // Plain window, wrapping when it runs past midnight.
            s = $urandom_range(0, SEC_PER_DAY - 1);
            e = s + $urandom_range(1, 14400);
            if (e >= SEC_PER_DAY) e -= SEC_PER_DAY;
          end
          9: begin
            s = $urandom_range(0, SEC_PER_DAY - 1);
            e = s;
          end
          10, 11: begin
            // Out of the day and ordered: never matches.
            s = $urandom_range(SEC_PER_DAY, 524286);
            e = $urandom_range(s + 1, 524287);
          end
          12, 13: begin
            s = $urandom_range(72000, SEC_PER_DAY - 1);
            e = $urandom_range(0, 14400);
          end
          14: begin
            // Out-of-day start that still matches through the wrap.
            s = $urandom_range(SEC_PER_DAY, 524287);
            e = $urandom_range(0, 600);
          end
          default: begin
            s = $urandom() & 32'h7FFFF;
            e = $urandom() & 32'h7FFFF;
          end
        endcase
        r.start_s = 19'(s);
        r.end_s   = 19'(e);
      end else begin
        r.cmd     = twrt_pkg::CMD_QUERY;
        r.start_s = 19'($urandom());
        r.end_s   = 19'($urandom());
        r.lvl     = 10'($urandom());
        case ($urandom_range(0, 9))
          0, 1, 2: r.ms = $urandom();
          3, 4, 5, 6, 7: begin
            // Aim at a window edge of a stored rule, on a random day.
            sec = SEC_PER_DAY;
            if (rule_total != 0) begin
              k = $urandom_range(0, rule_total - 1);
              case ($urandom_range(0, 3))
                0: sec = rule_start[k];
                1: sec = rule_end[k];
                2: sec = rule_end[k] - 1;
                default: sec = rule_start[k] - 1;
              endcase
            end
            if (sec < SEC_PER_DAY) begin
              t = $urandom_range(0, 48);
              t = (t * SEC_PER_DAY + sec) * MS_PER_SEC + $urandom_range(0, 999);
              r.ms = t[31:0];
            end else begin
              r.ms = $urandom();
            end
          end
          8: r.ms = 32'hFFFFFFFF - $urandom_range(0, 200000);
          default: r.ms = $urandom_range(0, 5000);
        endcase
      end
      offer_request(r, 1'b0, no_ans);
    end
    in_valid_i <= 1'b0;

    while (owed_answers.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d adds (%0d stored, %0d dropped on a full table), %0d queries (%0d hit).",
             n_stored + n_dropped, n_stored, n_dropped, n_queries, n_hits);
    $display("Output held off for %0d cycles once while requests kept coming; %0d mismatches.",
             HOLD_CYCLES, mismatches);
    if (mismatches == 0) begin
      $display("time_window_rule_table_top_test passed");
    end else begin
      $display("time_window_rule_table_top_test failed");
    end
    $finish;
  end

  // Result side: random back-pressure, one long hold-off, and a field-by-field check.
  initial begin : result_sink
    int unsigned gap;
    bit          rx_calm;
    sched_ans_t  want;
    rx_calm = 1'b0;
    wait (rst_ni);
    forever begin
      if ($urandom_range(0, 49) == 0) rx_calm = !rx_calm;
      if (answers_taken == HOLD_AT) gap = HOLD_CYCLES;
      else gap = rx_calm ? 0 : $urandom_range(0, 19);
      if (gap != 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      answers_taken++;
      if (owed_answers.size() == 0) begin
        report_mismatch("result with no request outstanding, status", status_o, 0);
      end else begin
        want = owed_answers.pop_front();
        if (status_o != want.st) report_mismatch("status", status_o, want.st);
        if (intensity_o != want.inten) report_mismatch("intensity", intensity_o, want.inten);
        if (matched_o != want.hit) report_mismatch("matched", matched_o, want.hit);
      end
    end
  end

  // Watchdog: ends the run when neither side moves a request for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("time_window_rule_table_top_test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
